[rtl/core/dclpr_pkg.sv]
// Shared types, constants and table functions for the dial code prefix rater.
// No dependencies; imported by the top level.
package dclpr_pkg;

    localparam int NAT_DIGITS  = 5;
    localparam int INT_DIGITS  = 3;
    localparam int NAT_DEPTH   = 111110;
    localparam int INT_DEPTH   = 1110;
    localparam int NAT_AW      = 17;
    localparam int INT_AW      = 11;

    localparam int OPCODE_W    = 1;
    localparam int ZONE_W      = 2;
    localparam int LEN_W       = 3;
    localparam int VALUE_W     = 17;
    localparam int RATE_W      = 17;
    localparam int TAG_W       = 16;
    localparam int BCD_W       = 20;
    localparam int DUR_W       = 17;
    localparam int CLASS_W     = 2;
    localparam int COST_W      = 34;
    localparam int ENTRY_W     = 1 + RATE_W + TAG_W;
    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 72;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_RATE = 1'b1;

    localparam logic [ZONE_W-1:0] ZONE_LOCAL = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_NAT   = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_INT   = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_UNDEF = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_LOCAL   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [RATE_W-1:0] rate;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // Offset of the block of entries for a given prefix length.
    function automatic logic [NAT_AW-1:0] block_base(input logic [LEN_W-1:0] len);
        logic [NAT_AW-1:0] base;
        case (len)
            3'd2:    base = 17'd10;
            3'd3:    base = 17'd110;
            3'd4:    base = 17'd1110;
            3'd5:    base = 17'd11110;
            default: base = 17'd0;
        endcase
        return base;
    endfunction

    // Number of entries in the block for a given prefix length.
    function automatic logic [VALUE_W-1:0] block_size(input logic [LEN_W-1:0] len);
        logic [VALUE_W-1:0] size;
        case (len)
            3'd1:    size = 17'd10;
            3'd2:    size = 17'd100;
            3'd3:    size = 17'd1000;
            3'd4:    size = 17'd10000;
            3'd5:    size = 17'd100000;
            default: size = 17'd1;
        endcase
        return size;
    endfunction

endpackage

[rtl/core/dclpr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dclpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/dial_code_longest_prefix_rater.sv]
// Longest-prefix call rater: prefix tables in two RAMs, load and query words.
// Depends on dclpr_pkg and dclpr_ram.
//
// Channel   Dir   Words                         Notes
// s_*       in    load entry / rate query       tuser = opcode
// m_*       out   one result per query          none for a load
//
// A load is written in the cycle it is accepted.
// A query walks the probe state, one read per probed digit (up to 5
// national, 3 international) through the single read port of its prefix
// RAM, and ends in the multiply state. Local and unknown-zone queries go
// straight to the multiply state. After reset a clearing pass writes every
// entry of both RAMs, one address a cycle; s_tready stays low during it.
// A pending result holds in the output register while m_tready is low; the
// next word is still accepted, and a query stalls only at its last cycle.
module dial_code_longest_prefix_rater (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // zone[1:0], prefix_length[4:2], prefix_value[21:5], rate_cents[38:22],
    // name_tag[54:39], dialed_bcd[74:55], duration_minutes[91:75], zero pad
    input  logic [dclpr_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [dclpr_pkg::OPCODE_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // call_class[1:0], matched_length[4:2], rate_out[21:5], tag_out[37:22],
    // cost_cents[71:38]
    output logic [dclpr_pkg::M_DATA_W-1:0] m_tdata
);
    import dclpr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;

    // input fields
    logic [ZONE_W-1:0]  in_zone;
    logic [LEN_W-1:0]   in_len;
    logic [VALUE_W-1:0] in_value;
    logic [RATE_W-1:0]  in_rate;
    logic [TAG_W-1:0]   in_tag;
    logic [BCD_W-1:0]   in_bcd;
    logic [DUR_W-1:0]   in_dur;

    assign in_zone  = s_tdata[1:0];
    assign in_len   = s_tdata[4:2];
    assign in_value = s_tdata[21:5];
    assign in_rate  = s_tdata[38:22];
    assign in_tag   = s_tdata[54:39];
    assign in_bcd   = s_tdata[74:55];
    assign in_dur   = s_tdata[91:75];

    logic [1:0]         state_reg, state_next;
    logic               clr_active_reg, clr_active_next;
    logic [NAT_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [ZONE_W-1:0]  zone_reg, zone_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   pend_len_reg, pend_len_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [RATE_W-1:0]  best_rate_reg, best_rate_next;
    logic [TAG_W-1:0]   best_tag_reg, best_tag_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // RAM ports
    logic               nat_we, int_we, nat_re, int_re;
    logic [NAT_AW-1:0]  nat_waddr, nat_raddr;
    logic [INT_AW-1:0]  int_waddr, int_raddr;
    entry_t             wr_entry, nat_rdata, int_rdata, rd_entry;

    // load path
    logic               in_fire, load_ok;
    logic [LEN_W-1:0]   load_limit;
    logic [NAT_AW-1:0]  load_addr;

    // probe path
    logic [LEN_W-1:0]   limit;
    logic [3:0]         digit;
    logic               issue;
    logic [20:0]        value_x10;
    logic [VALUE_W-1:0] probe_value;
    logic [NAT_AW-1:0]  probe_addr;
    logic               out_free;
    logic [COST_W-1:0]  product;
    logic [CLASS_W-1:0] out_class;

    assign s_tready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign load_limit = (in_zone == ZONE_NAT) ? LEN_W'(NAT_DIGITS) : LEN_W'(INT_DIGITS);
    assign load_ok = (in_zone == ZONE_NAT || in_zone == ZONE_INT) && (in_len != '0)
                     && (in_len <= load_limit) && (in_value < block_size(in_len));
    assign load_addr = block_base(in_len) + in_value;

    // Writes: clearing pass first, then accepted loads.
    always_comb begin
        wr_entry.valid = !clr_active_reg;
        wr_entry.rate  = clr_active_reg ? '0 : in_rate;
        wr_entry.tag   = clr_active_reg ? '0 : in_tag;
        if (clr_active_reg) begin
            nat_we    = 1'b1;
            int_we    = (clr_idx_reg < NAT_AW'(INT_DEPTH));
            nat_waddr = clr_idx_reg;
            int_waddr = clr_idx_reg[INT_AW-1:0];
        end else begin
            nat_we    = in_fire && (s_tuser == OP_LOAD) && load_ok && (in_zone == ZONE_NAT);
            int_we    = in_fire && (s_tuser == OP_LOAD) && load_ok && (in_zone == ZONE_INT);
            nat_waddr = load_addr;
            int_waddr = load_addr[INT_AW-1:0];
        end
    end

    // Probe address: extend the running prefix value by the next dialed digit.
    assign limit = (zone_reg == ZONE_NAT) ? LEN_W'(NAT_DIGITS) : LEN_W'(INT_DIGITS);

    always_comb begin
        case (len_reg)
            3'd1:    digit = bcd_reg[19:16];
            3'd2:    digit = bcd_reg[15:12];
            3'd3:    digit = bcd_reg[11:8];
            3'd4:    digit = bcd_reg[7:4];
            3'd5:    digit = bcd_reg[3:0];
            default: digit = 4'hf;
        endcase
    end

    assign issue       = (state_reg == ST_PROBE) && (len_reg <= limit) && (digit <= 4'd9);
    assign value_x10   = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0} + 21'(digit);
    assign probe_value = value_x10[VALUE_W-1:0];
    assign probe_addr  = block_base(len_reg) + probe_value;
    assign nat_raddr   = probe_addr;
    assign int_raddr   = probe_addr[INT_AW-1:0];
    assign nat_re      = issue && (zone_reg == ZONE_NAT);
    assign int_re      = issue && (zone_reg == ZONE_INT);
    assign rd_entry    = (zone_reg == ZONE_NAT) ? nat_rdata : int_rdata;

    assign product = COST_W'(dur_reg) * COST_W'(best_rate_reg);

    always_comb begin
        if (zone_reg == ZONE_LOCAL) begin
            out_class = CLASS_LOCAL;
        end else if (best_len_reg == '0) begin
            out_class = CLASS_UNKNOWN;
        end else begin
            out_class = zone_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        zone_next       = zone_reg;
        bcd_next        = bcd_reg;
        dur_next        = dur_reg;
        len_next        = len_reg;
        value_next      = value_reg;
        pend_next       = pend_reg;
        pend_len_next   = pend_len_reg;
        best_len_next   = best_len_reg;
        best_rate_next  = best_rate_reg;
        best_tag_next   = best_tag_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        if (clr_active_reg) begin
            clr_idx_next = clr_idx_reg + NAT_AW'(1);
            if (clr_idx_reg == NAT_AW'(NAT_DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_tuser == OP_RATE) begin
                    zone_next      = in_zone;
                    bcd_next       = in_bcd;
                    dur_next       = in_dur;
                    len_next       = LEN_W'(1);
                    value_next     = '0;
                    pend_next      = 1'b0;
                    best_len_next  = '0;
                    best_rate_next = '0;
                    best_tag_next  = '0;
                    if (in_zone == ZONE_NAT || in_zone == ZONE_INT) begin
                        state_next = ST_PROBE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_PROBE: begin
                // check the entry read in the previous cycle
                if (pend_reg && rd_entry.valid) begin
                    best_len_next  = pend_len_reg;
                    best_rate_next = rd_entry.rate;
                    best_tag_next  = rd_entry.tag;
                end
                pend_next     = issue;
                pend_len_next = len_reg;
                if (issue) begin
                    value_next = probe_value;
                    len_next   = len_reg + LEN_W'(1);
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {product, best_tag_reg, best_rate_reg, best_len_reg,
                                    out_class};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zone_reg      <= zone_next;
        bcd_reg       <= bcd_next;
        dur_reg       <= dur_next;
        len_reg       <= len_next;
        value_reg     <= value_next;
        pend_len_reg  <= pend_len_next;
        best_len_reg  <= best_len_next;
        best_rate_reg <= best_rate_next;
        best_tag_reg  <= best_tag_next;
        m_data_reg    <= m_data_next;
    end

    dclpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NAT_DEPTH)
    ) u_nat_ram (
        .aclk  (aclk),
        .we    (nat_we),
        .waddr (nat_waddr),
        .wdata (wr_entry),
        .re    (nat_re),
        .raddr (nat_raddr),
        .rdata (nat_rdata)
    );

    dclpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (INT_DEPTH)
    ) u_int_ram (
        .aclk  (aclk),
        .we    (int_we),
        .waddr (int_waddr),
        .wdata (wr_entry),
        .re    (int_re),
        .raddr (int_raddr),
        .rdata (int_rdata)
    );

endmodule

[sim/dial_code_rating_checker.sv]
// Result checker for the dial code prefix rater: watches both stream channels,
// predicts each rating from its own prefix tables and compares. Uses dclpr_pkg.
`timescale 1ns / 100ps

module dial_code_rating_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [dclpr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [dclpr_pkg::OPCODE_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dclpr_pkg::M_DATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             pending
);
    import dclpr_pkg::*;

    typedef struct {
        logic [CLASS_W-1:0] call_class;
        logic [LEN_W-1:0]   matched_length;
        logic [RATE_W-1:0]  rate;
        logic [TAG_W-1:0]   tag;
        logic [COST_W-1:0]  cost;
    } rating_t;

    // Keyed by block offset plus prefix value; a missing key is an invalid entry.
    entry_t  nat_prefixes[int];
    entry_t  intl_prefixes[int];
    rating_t expected_ratings[$];

    function automatic void store_prefix(input logic [ZONE_W-1:0] zone,
                                         input logic [LEN_W-1:0] len,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [RATE_W-1:0] rate,
                                         input logic [TAG_W-1:0] tag);
        int     limit;
        int     base;
        int     span;
        int     l;
        entry_t slot;
        if (zone != ZONE_NAT && zone != ZONE_INT) return;
        limit = (zone == ZONE_NAT) ? NAT_DIGITS : INT_DIGITS;
        if (len < 1 || len > limit) return;
        base = 0;
        span = 10;
        for (l = 1; l < len; l++) begin
            base += span;
            span *= 10;
        end
        if (value >= span) return;
        slot.valid = 1'b1;
        slot.rate  = rate;
        slot.tag   = tag;
        if (zone == ZONE_NAT) nat_prefixes[base + value] = slot;
        else                  intl_prefixes[base + value] = slot;
    endfunction

    function automatic rating_t rate_call(input logic [ZONE_W-1:0] zone,
                                          input logic [BCD_W-1:0] bcd,
                                          input logic [DUR_W-1:0] dur);
        rating_t     r;
        int          limit;
        int          base;
        int          span;
        int          value;
        int          len;
        bit          stopped;
        logic [3:0]  digit;
        logic [63:0] product;
        r.call_class     = CLASS_UNKNOWN;
        r.matched_length = '0;
        r.rate           = '0;
        r.tag            = '0;
        r.cost           = '0;
        if (zone == ZONE_LOCAL) begin
            r.call_class = CLASS_LOCAL;
            return r;
        end
        if (zone != ZONE_NAT && zone != ZONE_INT) return r;
        limit   = (zone == ZONE_NAT) ? NAT_DIGITS : INT_DIGITS;
        base    = 0;
        span    = 10;
        value   = 0;
        stopped = 1'b0;
        for (len = 1; len <= limit && !stopped; len++) begin
            digit = bcd[4*(5-len) +: 4];
            // a non-decimal digit ends the walk; nothing past it can match
            if (digit > 4'd9) begin
                stopped = 1'b1;
            end else begin
                value = value * 10 + digit;
                if (zone == ZONE_NAT && nat_prefixes.exists(base + value)) begin
                    r.matched_length = LEN_W'(len);
                    r.rate           = nat_prefixes[base + value].rate;
                    r.tag            = nat_prefixes[base + value].tag;
                end else if (zone == ZONE_INT && intl_prefixes.exists(base + value)) begin
                    r.matched_length = LEN_W'(len);
                    r.rate           = intl_prefixes[base + value].rate;
                    r.tag            = intl_prefixes[base + value].tag;
                end
                base += span;
                span *= 10;
            end
        end
        if (r.matched_length != 0) begin
            r.call_class = zone;
            product      = 64'(dur) * 64'(r.rate);
            r.cost       = product[COST_W-1:0];
        end
        return r;
    endfunction

    function automatic void note_failure(input string what, input longint unsigned want,
                                         input longint unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    always @(posedge aclk) begin
        rating_t want;
        if (!aresetn) begin
            fail_count = 0;
            pending    = 0;
            expected_ratings.delete();
            nat_prefixes.delete();
            intl_prefixes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_ratings.size() == 0) begin
                    note_failure("unexpected result word, cost", 0, m_tdata[71:38]);
                end else begin
                    want = expected_ratings.pop_front();
                    if (m_tdata[1:0] != want.call_class)
                        note_failure("call_class", want.call_class, m_tdata[1:0]);
                    if (m_tdata[4:2] != want.matched_length)
                        note_failure("matched_length", want.matched_length, m_tdata[4:2]);
                    if (m_tdata[21:5] != want.rate)
                        note_failure("rate_out", want.rate, m_tdata[21:5]);
                    if (m_tdata[37:22] != want.tag)
                        note_failure("tag_out", want.tag, m_tdata[37:22]);
                    if (m_tdata[71:38] != want.cost)
                        note_failure("cost_cents", want.cost, m_tdata[71:38]);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD)
                    store_prefix(s_tdata[1:0], s_tdata[4:2], s_tdata[21:5],
                                 s_tdata[38:22], s_tdata[54:39]);
                else
                    expected_ratings.push_back(rate_call(s_tdata[1:0], s_tdata[74:55],
                                                         s_tdata[91:75]));
            end
            pending = expected_ratings.size();
        end
    end

endmodule

[sim/dial_code_longest_prefix_rater_tb.sv]
// Testbench top for the dial code prefix rater: drives loads and rating queries
// with random gaps and stalls, and reports the verdict of dial_code_rating_checker.
`timescale 1ns / 100ps

module dial_code_longest_prefix_rater_tb;
    import dclpr_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OPCODE_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    logic [BCD_W-1:0]    nat_seeds [6];
    logic [BCD_W-1:0]    intl_seeds[4];
    int                  word_index;

    dial_code_longest_prefix_rater u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dial_code_rating_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Timeout for a hung run; the slowest correct run, clearing pass included, ends well before it.
    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [BCD_W-1:0] random_bcd();
        logic [BCD_W-1:0] digits;
        int d;
        for (d = 0; d < 5; d++) digits[4*d +: 4] = 4'($urandom_range(0, 9));
        return digits;
    endfunction

    task automatic send_word(input logic [OPCODE_W-1:0] opcode,
                             input logic [S_DATA_W-1:0] word);
        int gap;
        // every third stretch of 60 words goes without gaps
        gap = ((word_index / 60) % 3 == 2) ? 0 : $urandom_range(0, 13);
        word_index++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            s_tuser  <= OPCODE_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= opcode;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Unused fields of each word carry random bits.
    task automatic send_load(input logic [ZONE_W-1:0] zone, input logic [LEN_W-1:0] len,
                             input logic [VALUE_W-1:0] value,
                             input logic [RATE_W-1:0] rate, input logic [TAG_W-1:0] tag);
        logic [BCD_W-1:0] bcd;
        logic [DUR_W-1:0] dur;
        bcd = BCD_W'($urandom);
        dur = DUR_W'($urandom);
        send_word(OP_LOAD, {4'b0, dur, bcd, tag, rate, value, len, zone});
    endtask

    task automatic send_query(input logic [ZONE_W-1:0] zone, input logic [BCD_W-1:0] bcd,
                              input logic [DUR_W-1:0] dur);
        logic [LEN_W-1:0]   len;
        logic [VALUE_W-1:0] value;
        logic [RATE_W-1:0]  rate;
        logic [TAG_W-1:0]   tag;
        len   = LEN_W'($urandom);
        value = VALUE_W'($urandom);
        rate  = RATE_W'($urandom);
        tag   = TAG_W'($urandom);
        send_word(OP_RATE, {4'b0, dur, bcd, tag, rate, value, len, zone});
    endtask

    // Result side: random stall per word, quiet stretches, one long hold-off.
    initial begin : result_sink
        int stall;
        int taken;
        m_tready = 1'b0;
        taken    = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = ((taken / 40) % 4 == 1) ? 0 : $urandom_range(0, 13);
            if (taken == 120) stall = 400;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : stimulus
        logic [ZONE_W-1:0]  zone;
        logic [LEN_W-1:0]   len;
        logic [VALUE_W-1:0] value;
        logic [RATE_W-1:0]  rate;
        logic [BCD_W-1:0]   seed;
        logic [BCD_W-1:0]   bcd;
        logic [DUR_W-1:0]   dur;
        int                 n;
        int                 d;
        int                 keep;
        int                 pick;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_LOAD;
        aresetn    = 1'b0;
        word_index = 0;
        foreach (nat_seeds[i])  nat_seeds[i]  = random_bcd();
        foreach (intl_seeds[i]) intl_seeds[i] = random_bcd();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed part; the first word waits out the clearing pass
        send_query(ZONE_LOCAL, 20'h12345, 17'd500);
        send_query(ZONE_UNDEF, 20'h12345, 17'd500);
        send_query(ZONE_NAT, 20'h00000, 17'd10);
        send_load(ZONE_NAT, 3'd1, 17'd0, 17'd0, 16'd0);
        send_load(ZONE_NAT, 3'd5, 17'd99999, 17'd99999, 16'hFFFF);
        send_load(ZONE_INT, 3'd3, 17'd999, 17'h1FFFF, 16'hFFFF);
        send_load(ZONE_INT, 3'd1, 17'd5, 17'd1, 16'd1);
        send_load(ZONE_LOCAL, 3'd1, 17'd1, 17'd77, 16'd77);
        send_load(ZONE_UNDEF, 3'd1, 17'd1, 17'd77, 16'd77);
        send_load(ZONE_NAT, 3'd0, 17'd0, 17'd77, 16'd77);
        send_load(ZONE_NAT, 3'd6, 17'd1, 17'd77, 16'd77);
        send_load(ZONE_INT, 3'd4, 17'd1234, 17'd77, 16'd77);
        send_load(ZONE_NAT, 3'd7, 17'h1FFFF, 17'd77, 16'd77);
        send_load(ZONE_NAT, 3'd2, 17'd100, 17'd77, 16'd77);
        send_query(ZONE_NAT, 20'h10000, 17'd3);
        // overwrite an existing entry
        send_load(ZONE_NAT, 3'd1, 17'd0, 17'd12345, 16'hABCD);
        send_query(ZONE_NAT, 20'h99999, 17'd99999);
        send_query(ZONE_NAT, 20'h01234, 17'd7);
        send_query(ZONE_INT, 20'h99900, 17'h1FFFF);
        send_query(ZONE_INT, 20'h5A000, 17'd40);
        send_query(ZONE_NAT, 20'hF0000, 17'd40);
        send_query(ZONE_NAT, 20'h9999A, 17'd2);
        send_query(ZONE_LOCAL, 20'hFFFFF, 17'h1FFFF);

        // random part: nested prefixes grown from a few seed numbers per zone
        for (n = 0; n < 700; n++) begin
            if (n % 100 == 99) begin
                nat_seeds[$urandom_range(0, 5)]  = random_bcd();
                intl_seeds[$urandom_range(0, 3)] = random_bcd();
            end
            zone = ($urandom_range(0, 1) == 0) ? ZONE_NAT : ZONE_INT;
            seed = (zone == ZONE_NAT) ? nat_seeds[$urandom_range(0, 5)]
                                      : intl_seeds[$urandom_range(0, 3)];
            rate = ($urandom_range(0, 9) == 0) ? RATE_W'($urandom)
                                               : RATE_W'($urandom_range(0, 99999));
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 99) < 85) begin
                    len   = LEN_W'($urandom_range(1,
                                (zone == ZONE_NAT) ? NAT_DIGITS : INT_DIGITS));
                    value = '0;
                    for (d = 0; d < len; d++)
                        value = VALUE_W'(value * 10 + seed[4*(4-d) +: 4]);
                end else begin
                    // malformed or ignored loads
                    zone  = ZONE_W'($urandom_range(0, 3));
                    len   = LEN_W'($urandom_range(0, 7));
                    value = VALUE_W'($urandom);
                end
                send_load(zone, len, value, rate, 16'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick >= 90)      zone = ZONE_UNDEF;
                else if (pick >= 80) zone = ZONE_LOCAL;
                if ($urandom_range(0, 99) < 85) begin
                    keep = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(0, 5);
                    bcd  = seed;
                    for (d = keep; d < 5; d++) bcd[4*(4-d) +: 4] = 4'($urandom_range(0, 9));
                    if ($urandom_range(0, 9) == 0)
                        bcd[4*$urandom_range(0, 4) +: 4] = 4'($urandom_range(10, 15));
                end else begin
                    bcd = BCD_W'($urandom);
                end
                dur = ($urandom_range(0, 9) == 0) ? DUR_W'($urandom)
                                                  : DUR_W'($urandom_range(0, 99999));
                send_query(zone, bcd, dur);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
